// File: rtl/bcgau_pkg.sv
// Shared types, constants and helpers for the block-cyclic global address unit.
// No dependencies; every other file of the unit imports this package.
package bcgau_pkg;

    localparam int ADDR_W        = 64;
    localparam int CFG_W         = 17;
    localparam int BS_W          = 32;
    localparam int RANK_IN_W     = 16;
    localparam int OP_W          = 3;
    localparam int LB_W          = 5;
    localparam int RB_W          = 5;
    localparam int SHIFT_W       = 7;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_STAGES    = 64;
    localparam int DEF_MAX_RANKS = 65536;

    typedef enum logic [OP_W-1:0] {
        OP_RANK     = 3'd0,
        OP_OFFSET   = 3'd1,
        OP_COMPOSE  = 3'd2,
        OP_ADD      = 3'd3,
        OP_SUB      = 3'd4,
        OP_ADD_CYC  = 3'd5,
        OP_SUB_CYC  = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        K_DONE,
        K_CADD,
        K_CSUB
    } t_kind;

    // One classified item. For K_DONE res/aux are the final address and
    // difference. For K_CADD res is the block number, aux the new phase, qv the
    // shifted amount and carry the phase overflow. For K_CSUB res is the block
    // difference, aux the phase difference and rk the rank difference.
    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] res;
        logic [ADDR_W-1:0] aux;
        logic [ADDR_W-1:0] qv;
        logic              carry;
        logic              neg;
        logic [CFG_W:0]    rk;
        logic [LB_W-1:0]   lb;
        logic              err;
    } t_work;

    function automatic logic [CFG_W-1:0] rank_of(input logic [ADDR_W-1:0] a,
                                                 input logic [RB_W-1:0]   rb);
        logic [ADDR_W-1:0] sh;
        sh = a >> (SHIFT_W'(ADDR_W) - {2'b0, rb});
        return sh[CFG_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] rank_field(input logic [CFG_W-1:0] r,
                                                     input logic [RB_W-1:0]  rb);
        logic [ADDR_W-1:0] ext;
        ext = {{(ADDR_W-CFG_W){1'b0}}, r};
        return ext << (SHIFT_W'(ADDR_W) - {2'b0, rb});
    endfunction

endpackage

// File: rtl/bcgau_if.sv
// Handshake channels of the unit: request, response and configuration write.
// Depends on bcgau_pkg for field widths.
interface bcgau_req_if;
    import bcgau_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [OP_W-1:0]             operation;
    logic [ADDR_W-1:0]           address_a;
    logic [ADDR_W-1:0]           address_b;
    logic signed [ADDR_W-1:0]    amount;
    logic [BS_W-1:0]             block_size;
    logic [RANK_IN_W-1:0]        rank_in;
    logic [ADDR_W-1:0]           offset_in;
    modport source (output valid, operation, address_a, address_b, amount,
                    block_size, rank_in, offset_in, input ready);
    modport sink   (input valid, operation, address_a, address_b, amount,
                    block_size, rank_in, offset_in, output ready);
endinterface

interface bcgau_rsp_if;
    import bcgau_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [ADDR_W-1:0]        address_out;
    logic signed [ADDR_W-1:0] difference;
    logic                     error;
    modport source (output valid, address_out, difference, error, input ready);
    modport sink   (input valid, address_out, difference, error, output ready);
endinterface

interface bcgau_cfg_if;
    import bcgau_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] rank_count;
    modport source (output valid, rank_count, input ready);
    modport sink   (input valid, rank_count, output ready);
endinterface

// File: rtl/bcgau_front.sv
// Front end: decodes each request and reduces it to a classified work item.
// Depends on bcgau_pkg and bcgau_if.
module bcgau_front (
    bcgau_req_if.sink                  i_req,
    input  logic                       i_full,
    input  logic [bcgau_pkg::CFG_W-1:0] i_ranks,
    input  logic [bcgau_pkg::RB_W-1:0]  i_rb,
    output logic                       o_push,
    output bcgau_pkg::t_work           o_work
);
    import bcgau_pkg::*;

    t_op               opc;
    logic              bs_zero;
    logic              bs_bad;
    logic [LB_W-1:0]   lb;
    logic [BS_W-1:0]   pmask;
    logic [CFG_W-1:0]  ra;
    logic [CFG_W-1:0]  rbk;
    logic              ra_bad;
    logic              rbk_bad;
    logic              rin_bad;
    logic [ADDR_W-1:0] omask;
    logic [BS_W-1:0]   phase;
    logic [BS_W-1:0]   rpart;
    logic [BS_W:0]     ps;
    t_work             w;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;
    assign o_work      = w;

    always_comb begin
        lb = '0;
        for (int k = 0; k < BS_W; k++) begin
            if (i_req.block_size[k]) begin
                lb = LB_W'(k);
            end
        end
        bs_zero = (i_req.block_size == '0);
        pmask   = i_req.block_size - BS_W'(1);
        bs_bad  = !bs_zero && ((i_req.block_size & pmask) != '0);
        ra      = rank_of(i_req.address_a, i_rb);
        rbk     = rank_of(i_req.address_b, i_rb);
        ra_bad  = (ra >= i_ranks);
        rbk_bad = (rbk >= i_ranks);
        rin_bad = ({1'b0, i_req.rank_in} >= i_ranks);
        omask   = {ADDR_W{1'b1}} >> i_rb;
        phase   = i_req.address_a[BS_W-1:0] & pmask;
        rpart   = i_req.amount[BS_W-1:0] & pmask;
        ps      = {1'b0, phase} + {1'b0, rpart};

        // zero block size falls back to the linear forms
        opc = t_op'(i_req.operation);
        if (bs_zero && opc == OP_ADD_CYC) begin
            opc = OP_ADD;
        end
        if (bs_zero && opc == OP_SUB_CYC) begin
            opc = OP_SUB;
        end

        w      = '0;
        w.kind = K_DONE;
        w.lb   = lb;
        if (bs_bad && (opc inside {OP_ADD_CYC, OP_SUB_CYC})) begin
            w.err = 1'b1;
        end else begin
            case (opc)
                OP_RANK: begin
                    w.res = {{(ADDR_W-CFG_W){1'b0}}, ra};
                    w.err = ra_bad;
                end
                OP_OFFSET: begin
                    w.res = i_req.address_a & omask;
                    w.err = ra_bad;
                end
                OP_COMPOSE: begin
                    w.res = rank_field({1'b0, i_req.rank_in}, i_rb) + i_req.offset_in;
                    w.err = rin_bad;
                end
                OP_ADD: begin
                    w.res = i_req.address_a + i_req.amount;
                    w.err = ra_bad;
                end
                OP_SUB: begin
                    w.aux = i_req.address_a - i_req.address_b;
                    w.err = ra_bad || rbk_bad || (ra != rbk);
                end
                OP_ADD_CYC: begin
                    w.kind  = K_CADD;
                    w.res   = (i_req.address_a & omask) >> lb;
                    w.aux   = {{(ADDR_W-BS_W){1'b0}}, ps[BS_W-1:0] & pmask};
                    w.carry = ps[lb];
                    w.qv    = $unsigned(i_req.amount >>> lb);
                    w.rk    = {1'b0, ra};
                    w.err   = ra_bad;
                end
                OP_SUB_CYC: begin
                    w.kind = K_CSUB;
                    w.res  = ((i_req.address_a & omask) >> lb)
                           - ((i_req.address_b & omask) >> lb);
                    w.aux  = {{(ADDR_W-BS_W){1'b0}}, i_req.address_a[BS_W-1:0] & pmask}
                           - {{(ADDR_W-BS_W){1'b0}}, i_req.address_b[BS_W-1:0] & pmask};
                    w.rk   = {1'b0, ra} - {1'b0, rbk};
                    w.err  = ra_bad || rbk_bad;
                end
                default: begin
                    w.err = 1'b1;
                end
            endcase
        end
    end

endmodule

// File: rtl/bcgau_queue.sv
// Short work queue between front and back end.
// Depends on bcgau_pkg for the work item type and depth.
module bcgau_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bcgau_pkg::t_work i_work,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output bcgau_pkg::t_work o_work
);
    import bcgau_pkg::*;

    t_work             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_work  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

endmodule

// File: rtl/bcgau_back.sv
// Back end: pipelined floor division by the rank count, cyclic finish steps
// and the output register. Depends on bcgau_pkg and bcgau_if.
module bcgau_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bcgau_pkg::t_work            i_work,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  logic [bcgau_pkg::CFG_W-1:0] i_ranks,
    input  logic [bcgau_pkg::RB_W-1:0]  i_rb,
    bcgau_rsp_if.source                 o_rsp
);
    import bcgau_pkg::*;

    localparam int MW = BS_W + CFG_W;

    logic              adv;
    logic [ADDR_W-1:0] n_q;
    t_work             n_dw0;

    // division stages: index 0 is the prep stage, DIV_STAGES is the last
    logic              r_dv   [DIV_STAGES+1];
    t_work             r_dw   [DIV_STAGES+1];
    logic [CFG_W-1:0]  r_rem  [DIV_STAGES+1];
    logic [ADDR_W-1:0] r_quo  [DIV_STAGES+1];
    logic [CFG_W-1:0]  n_rem  [DIV_STAGES];
    logic              n_bit  [DIV_STAGES];

    logic              r_v1, r_v2, r_v3, r_ov;
    t_work             r_w1, r_w2, r_w3;
    logic [ADDR_W-1:0] r_qb1;
    logic [CFG_W:0]    r_s1;
    logic [MW-1:0]     r_mlo1, r_mlo2;
    logic [ADDR_W-1:0] r_cyc2;
    logic [CFG_W-1:0]  r_nr2, r_nr3;
    logic [BS_W-1:0]   r_mhi2;
    logic [ADDR_W-1:0] r_blk3;
    logic [ADDR_W-1:0] r_t3;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_diff;
    logic              r_err;

    logic [ADDR_W-1:0] n_qb;
    logic [CFG_W-1:0]  n_rr;
    logic [CFG_W:0]    n_s;
    logic [ADDR_W-1:0] n_cyc;
    logic [CFG_W-1:0]  n_nr;
    logic [SHIFT_W-1:0] n_msh;
    logic [ADDR_W-1:0] n_addr;
    logic [ADDR_W-1:0] n_diff;

    assign adv   = !r_ov || o_rsp.ready;
    assign o_pop = adv && !i_empty;

    assign o_rsp.valid       = r_ov;
    assign o_rsp.address_out = r_addr;
    assign o_rsp.difference  = r_diff;
    assign o_rsp.error       = r_err;

    // restoring division, one quotient bit per stage
    always_comb begin
        n_q = i_work.qv + {{(ADDR_W-1){1'b0}}, i_work.carry};
        n_dw0     = i_work;
        n_dw0.neg = n_q[ADDR_W-1];
        for (int i = 0; i < DIV_STAGES; i++) begin
            logic [CFG_W:0] t;
            t        = {r_rem[i], r_quo[i][ADDR_W-1]};
            n_bit[i] = (t >= {1'b0, i_ranks});
            n_rem[i] = n_bit[i] ? CFG_W'(t - {1'b0, i_ranks}) : t[CFG_W-1:0];
        end
    end

    // floor correction, rank carry and result select
    always_comb begin
        n_qb = r_quo[DIV_STAGES];
        n_rr = r_rem[DIV_STAGES];
        if (r_dw[DIV_STAGES].neg) begin
            if (r_rem[DIV_STAGES] == '0) begin
                n_qb = '0 - r_quo[DIV_STAGES];
            end else begin
                n_qb = ~r_quo[DIV_STAGES];
                n_rr = i_ranks - r_rem[DIV_STAGES];
            end
        end
        n_s = {1'b0, r_dw[DIV_STAGES].rk[CFG_W-1:0]} + {1'b0, n_rr};

        n_cyc = r_qb1;
        n_nr  = r_s1[CFG_W-1:0];
        if (r_s1 >= {i_ranks, 1'b0}) begin
            n_cyc = r_qb1 + ADDR_W'(2);
            n_nr  = CFG_W'(r_s1 - {i_ranks, 1'b0});
        end else if (r_s1 >= {1'b0, i_ranks}) begin
            n_cyc = r_qb1 + ADDR_W'(1);
            n_nr  = CFG_W'(r_s1 - {1'b0, i_ranks});
        end

        n_msh = {2'b0, i_rb} + {2'b0, r_w2.lb};

        case (r_w3.kind)
            K_CADD: begin
                n_addr = rank_field(r_nr3, i_rb) | (r_blk3 << r_w3.lb) | r_w3.aux;
                n_diff = '0;
            end
            K_CSUB: begin
                n_addr = '0;
                n_diff = (r_t3 << r_w3.lb) + r_w3.aux;
            end
            default: begin
                n_addr = r_w3.res;
                n_diff = r_w3.aux;
            end
        endcase
    end

    // control: advance the whole chain together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= DIV_STAGES; i++) begin
                r_dv[i] <= 1'b0;
            end
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_dv[0] <= !i_empty;
            for (int i = 0; i < DIV_STAGES; i++) begin
                r_dv[i+1] <= r_dv[i];
            end
            r_v1 <= r_dv[DIV_STAGES];
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_ov <= r_v3;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dw[0]     <= n_dw0;
            r_quo[0]    <= n_q[ADDR_W-1] ? ('0 - n_q) : n_q;
            r_rem[0]    <= '0;
            for (int i = 0; i < DIV_STAGES; i++) begin
                r_dw[i+1]  <= r_dw[i];
                r_rem[i+1] <= n_rem[i];
                r_quo[i+1] <= {r_quo[i][ADDR_W-2:0], n_bit[i]};
            end

            r_w1   <= r_dw[DIV_STAGES];
            r_qb1  <= n_qb;
            r_s1   <= n_s;
            r_mlo1 <= MW'(r_dw[DIV_STAGES].res[BS_W-1:0]) * MW'(i_ranks);

            r_w2   <= r_w1;
            r_cyc2 <= n_cyc;
            r_nr2  <= n_nr;
            r_mlo2 <= r_mlo1;
            r_mhi2 <= BS_W'(MW'(r_w1.res[ADDR_W-1:BS_W]) * MW'(i_ranks));

            r_w3   <= r_w2;
            r_nr3  <= r_nr2;
            r_blk3 <= (r_w2.res + r_cyc2) & ({ADDR_W{1'b1}} >> n_msh);
            r_t3   <= {{(ADDR_W-MW){1'b0}}, r_mlo2} + {r_mhi2, {BS_W{1'b0}}}
                    + {{(ADDR_W-CFG_W-1){r_w2.rk[CFG_W]}}, r_w2.rk};

            r_addr <= n_addr;
            r_diff <= n_diff;
            r_err  <= r_w3.err;
        end
    end

endmodule

// File: rtl/block_cyclic_global_address_unit_core.sv
// Top level of the block-cyclic global address unit.
// Depends on bcgau_pkg, bcgau_if, bcgau_front, bcgau_queue and bcgau_back.
//
// Usage:
//   i_req  carries one operation per transfer (rank, offset, compose, linear
//          add/sub, cyclic add/sub). o_rsp returns exactly one result per
//          request, in request order. i_cfg writes the rank count; write it
//          only while no request is in flight. The config channel is always
//          ready.
//   Throughput: one transfer per cycle in and out when o_rsp is not stalled.
//   Path:  every item runs through a prep stage, the 64-stage divider by
//          the rank count (one quotient bit per stage), three finish stages
//          and the output register.
//   Stall: when o_rsp is valid and o_rsp.ready is low the whole back
//          pipeline holds; the 4-entry work queue absorbs requests until
//          full, then i_req.ready drops.
//   Reset: synchronous, active low. Clears the queue and all valid bits and
//          sets the rank count to 1 (single rank, rank field empty).
module block_cyclic_global_address_unit_core #(
    parameter int MAX_RANKS = bcgau_pkg::DEF_MAX_RANKS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcgau_req_if.sink   i_req,
    bcgau_rsp_if.source o_rsp,
    bcgau_cfg_if.sink   i_cfg
);
    import bcgau_pkg::*;

    localparam int CLAMP_W = 21;

    logic [CFG_W-1:0] r_ranks;
    logic [RB_W-1:0]  r_rb;
    logic [CFG_W-1:0] n_ranks;
    logic [RB_W-1:0]  n_rb;

    logic  full;
    logic  empty;
    logic  push;
    logic  pop;
    t_work push_work;
    t_work pop_work;

    assign i_cfg.ready = 1'b1;

    // clamp the written count into 1..MAX_RANKS, then find its ceil log2
    always_comb begin
        n_ranks = i_cfg.rank_count;
        if (i_cfg.rank_count == '0) begin
            n_ranks = CFG_W'(1);
        end else if ({{(CLAMP_W-CFG_W){1'b0}}, i_cfg.rank_count} > CLAMP_W'(MAX_RANKS)) begin
            n_ranks = CFG_W'(MAX_RANKS);
        end
        n_rb = '0;
        for (int k = CFG_W; k >= 0; k--) begin
            if (((CFG_W+1)'(1) << k) >= {1'b0, n_ranks}) begin
                n_rb = RB_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ranks <= CFG_W'(1);
            r_rb    <= '0;
        end else if (i_cfg.valid) begin
            r_ranks <= n_ranks;
            r_rb    <= n_rb;
        end
    end

    // classify and push
    bcgau_front u_front (
        .i_req   (i_req),
        .i_full  (full),
        .i_ranks (r_ranks),
        .i_rb    (r_rb),
        .o_push  (push),
        .o_work  (push_work)
    );

    // decouple front from back
    bcgau_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (push_work),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_work  (pop_work)
    );

    // divide, finish and hold the result
    bcgau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_work  (pop_work),
        .i_empty (empty),
        .o_pop   (pop),
        .i_ranks (r_ranks),
        .i_rb    (r_rb),
        .o_rsp   (o_rsp)
    );

endmodule
